[sv/nsf_pkg.sv]
// Package for the NMEA sentence framer: register indexes, default sizes,
// the "$GPTXT" prefix table and the flag group passed to the output stage.
// No dependencies.
`timescale 1ns / 1ps

package nsf_pkg;

    localparam int DEF_BUF_BYTES  = 128;
    localparam int DEF_SLOT_COUNT = 2;

    localparam int CFG_IDX_W  = 8;
    localparam int BYTE_W     = 8;
    localparam int PREFIX_LEN = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 8'd1;

    localparam logic [BYTE_W-1:0] RST_START_CHAR = 8'h24;
    localparam logic [BYTE_W-1:0] RST_END_CHAR   = 8'h0A;

    typedef struct packed {
        logic byte_valid;
        logic sentence_end;
        logic configure_request;
        logic baud_switch_request;
    } t_flags;

    // Expected character of the configure prefix at a given position.
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h54;
            3'd4:    c = 8'h58;
            3'd5:    c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[sv/nsf_core.sv]
// Framing state and per-byte decision logic of the NMEA sentence framer,
// together with the start and end character registers. Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_core #(
    parameter int BUF_BYTES  = nsf_pkg::DEF_BUF_BYTES,
    parameter int SLOT_COUNT = nsf_pkg::DEF_SLOT_COUNT,
    parameter int POS_W      = $clog2(BUF_BYTES),
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [nsf_pkg::BYTE_W-1:0]        i_rx_byte,
    input  logic                              i_cfg_write,
    input  logic [nsf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nsf_pkg::BYTE_W-1:0]        i_cfg_data,
    output logic                              o_res_valid,
    output nsf_pkg::t_flags                   o_flags,
    output logic [SLOT_W-1:0]                 o_slot_index,
    output logic [POS_W-1:0]                  o_byte_position,
    output logic [nsf_pkg::BYTE_W-1:0]        o_out_byte,
    output logic [POS_W-1:0]                  o_sentence_length
);
    import nsf_pkg::*;

    logic [BYTE_W-1:0] r_start_char;
    logic [BYTE_W-1:0] r_end_char;
    logic              r_in_sentence, n_in_sentence;
    logic [POS_W-1:0]  r_fill, n_fill;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_prefix, n_prefix;
    logic              r_all_written, n_all_written;
    logic              r_request_done, n_request_done;

    logic              is_start, is_end, place, wrap, mismatch;
    logic              cfg_req, baud_req;
    logic [POS_W-1:0]  pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= RST_START_CHAR;
            r_end_char   <= RST_END_CHAR;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                CFG_START_CHAR: r_start_char <= i_cfg_data;
                CFG_END_CHAR:   r_end_char   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // A start character wins over an end character of the same value.
        is_start = (i_rx_byte == r_start_char);
        is_end   = !is_start && (i_rx_byte == r_end_char);
        place    = is_start || is_end || r_in_sentence;
        pos      = is_start ? '0 : r_fill;
        wrap     = (pos == POS_W'(BUF_BYTES - 1));
        mismatch = (pos < POS_W'(PREFIX_LEN)) && (i_rx_byte != prefix_char(pos[2:0]));

        n_prefix      = r_prefix;
        n_all_written = r_all_written;
        n_fill        = r_fill;
        if (place) begin
            n_prefix      = (is_start || r_prefix) && !mismatch;
            n_all_written = (!is_start && r_all_written) || wrap;
            n_fill        = wrap ? '0 : pos + POS_W'(1);
        end

        // A sentence that never reached the sixth position cannot match, since
        // unwritten prefix positions hold no data of this sentence.
        cfg_req  = is_end && r_in_sentence && !r_request_done && n_prefix &&
                   ((pos >= POS_W'(PREFIX_LEN - 1)) || n_all_written);
        baud_req = !place && !r_request_done;
        n_request_done = r_request_done || cfg_req || baud_req;

        n_in_sentence = is_start ? 1'b1 : (is_end ? 1'b0 : r_in_sentence);
        n_slot = r_slot;
        if (is_end) begin
            n_slot = (r_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_slot + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence  <= 1'b0;
            r_fill         <= '0;
            r_slot         <= '0;
            r_prefix       <= 1'b0;
            r_all_written  <= 1'b0;
            r_request_done <= 1'b0;
        end else if (i_accept) begin
            r_in_sentence  <= n_in_sentence;
            r_fill         <= n_fill;
            r_slot         <= n_slot;
            r_prefix       <= n_prefix;
            r_all_written  <= n_all_written;
            r_request_done <= n_request_done;
        end
    end

    always_comb begin
        o_res_valid                 = place || baud_req;
        o_flags.byte_valid          = place;
        o_flags.sentence_end        = is_end;
        o_flags.configure_request   = cfg_req;
        o_flags.baud_switch_request = baud_req;
        o_slot_index      = place ? r_slot : '0;
        o_byte_position   = place ? pos : '0;
        o_out_byte        = place ? i_rx_byte : '0;
        o_sentence_length = place ? n_fill : '0;
    end

`ifndef SYNTHESIS
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_request_done) |-> r_request_done)
        else $error("request done flag cleared outside reset");
    a_req_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (cfg_req || baud_req) |=> r_request_done)
        else $error("request raised without setting the done flag");
    a_cfg_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_req |-> place && is_end && !baud_req)
        else $error("configure request not on a placed end character");
    a_baud_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        baud_req |-> !r_in_sentence && !is_start && !is_end)
        else $error("baud request on a byte that belongs to a sentence");
`endif

endmodule

[sv/nsf_out_reg.sv]
// Result register of the NMEA sentence framer; holds one result while the
// consumer stalls and accepts a new one as the old one leaves. Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_out_reg #(
    parameter int POS_W  = 7,
    parameter int SLOT_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic                       i_res_valid,
    input  nsf_pkg::t_flags            i_flags,
    input  logic [SLOT_W-1:0]          i_slot_index,
    input  logic [POS_W-1:0]           i_byte_position,
    input  logic [nsf_pkg::BYTE_W-1:0] i_out_byte,
    input  logic [POS_W-1:0]           i_sentence_length,
    input  logic                       i_ready,
    output logic                       o_space,
    output logic                       o_valid,
    output nsf_pkg::t_flags            o_flags,
    output logic [SLOT_W-1:0]          o_slot_index,
    output logic [POS_W-1:0]           o_byte_position,
    output logic [nsf_pkg::BYTE_W-1:0] o_out_byte,
    output logic [POS_W-1:0]           o_sentence_length
);
    import nsf_pkg::*;

    logic r_valid;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            o_flags           <= i_flags;
            o_slot_index      <= i_slot_index;
            o_byte_position   <= i_byte_position;
            o_out_byte        <= i_out_byte;
            o_sentence_length <= i_sentence_length;
        end
    end

endmodule

[sv/nmea_sentence_framer.sv]
// NMEA sentence framer: one byte accepted per cycle, its result registered and
// shown on o_valid in the cycle after acceptance; throughput one byte every cycle,
// limited only by the single result register when the consumer stalls.
// A byte that causes no result still takes its cycle and updates the state.
// Synchronous active-low reset returns the characters to '$' and line feed
// and clears all framing state; no memory needs clearing.
`timescale 1ns / 1ps

module nmea_sentence_framer #(
    parameter int BUF_BYTES  = nsf_pkg::DEF_BUF_BYTES,
    parameter int SLOT_COUNT = nsf_pkg::DEF_SLOT_COUNT,
    parameter int POS_W      = $clog2(BUF_BYTES),
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [nsf_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nsf_pkg::BYTE_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_byte_valid,
    output logic [SLOT_W-1:0]             o_slot_index,
    output logic [POS_W-1:0]              o_byte_position,
    output logic [nsf_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_sentence_end,
    output logic [POS_W-1:0]              o_sentence_length,
    output logic                          o_configure_request,
    output logic                          o_baud_switch_request
);
    import nsf_pkg::*;

    logic              accept, res_valid, space;
    t_flags            res_flags, out_flags;
    logic [SLOT_W-1:0] res_slot;
    logic [POS_W-1:0]  res_pos, res_len;
    logic [BYTE_W-1:0] res_byte;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = space;
    assign accept      = i_valid && space;

    nsf_core #(
        .BUF_BYTES (BUF_BYTES),
        .SLOT_COUNT(SLOT_COUNT),
        .POS_W     (POS_W),
        .SLOT_W    (SLOT_W)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_write      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_res_valid      (res_valid),
        .o_flags          (res_flags),
        .o_slot_index     (res_slot),
        .o_byte_position  (res_pos),
        .o_out_byte       (res_byte),
        .o_sentence_length(res_len)
    );

    nsf_out_reg #(
        .POS_W (POS_W),
        .SLOT_W(SLOT_W)
    ) u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (i_valid),
        .i_res_valid      (res_valid),
        .i_flags          (res_flags),
        .i_slot_index     (res_slot),
        .i_byte_position  (res_pos),
        .i_out_byte       (res_byte),
        .i_sentence_length(res_len),
        .i_ready          (i_ready),
        .o_space          (space),
        .o_valid          (o_valid),
        .o_flags          (out_flags),
        .o_slot_index     (o_slot_index),
        .o_byte_position  (o_byte_position),
        .o_out_byte       (o_out_byte),
        .o_sentence_length(o_sentence_length)
    );

    assign o_byte_valid          = out_flags.byte_valid;
    assign o_sentence_end        = out_flags.sentence_end;
    assign o_configure_request   = out_flags.configure_request;
    assign o_baud_switch_request = out_flags.baud_switch_request;

endmodule
